// ----- hw/rtl/kal_pkg.sv -----
// Shared widths, function codes and controller state type for the k-th ancestor block.
package kal_pkg;

   localparam int NODE_W  = 10;
   localparam int STEPS_W = 20;
   localparam int COUNT_W = 11;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_P_RD   = 9'b000000010,
      S_P_WR   = 9'b000000100,
      S_L_RD1  = 9'b000001000,
      S_L_RD2  = 9'b000010000,
      S_L_WR   = 9'b000100000,
      S_Q_RD   = 9'b001000000,
      S_Q_CHK  = 9'b010000000,
      S_RSP    = 9'b100000000
   } state_type;

endpackage

// ----- hw/rtl/kal_parent_mem.sv -----
// Parent store: one entry per node, synchronous write, registered read.
module kal_parent_mem import kal_pkg::*; #(
   parameter int MAX_NODES = 1024
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_NODES)-1:0] wr_idx,
   input  logic [NODE_W-1:0]            wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_NODES)-1:0] rd_idx,
   output logic [NODE_W-1:0]            rd_data
);

   logic [NODE_W-1:0] store_ff [MAX_NODES];
   logic [NODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/kal_lift_mem.sv -----
// Doubling table: entry (level, node) holds the node 2^level steps up, or the no-node code.
module kal_lift_mem #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 11
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(LEVELS)-1:0]      wr_lvl,
   input  logic [$clog2(MAX_NODES)-1:0]   wr_idx,
   input  logic [$clog2(MAX_NODES+1)-1:0] wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(LEVELS)-1:0]      rd_lvl,
   input  logic [$clog2(MAX_NODES)-1:0]   rd_idx,
   output logic [$clog2(MAX_NODES+1)-1:0] rd_data
);

   localparam int AW    = $clog2(MAX_NODES + 1);
   localparam int DEPTH = MAX_NODES * LEVELS;
   localparam int LW    = $clog2(DEPTH);

   logic [AW-1:0] table_ff [DEPTH];
   logic [AW-1:0] rd_data_ff;
   logic [LW-1:0] wr_addr;
   logic [LW-1:0] rd_addr;

   // level-major layout: level * MAX_NODES + node
   assign wr_addr = LW'(wr_lvl) * LW'(MAX_NODES) + LW'(wr_idx);
   assign rd_addr = LW'(rd_lvl) * LW'(MAX_NODES) + LW'(rd_idx);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/kth_ancestor_binary_lifting.sv -----
// Top level: k-th ancestor query engine with parent store, doubling table and controller.
//
//  - req_ channel carries one item per beat. func=0 writes the parent of req_node into the
//    parent store in the accept cycle and gives no response. func=1 asks for the node
//    req_steps levels above req_node and gives exactly one rsp_ beat.
//  - csr_wr_en/csr_wr_data set the node count (0 acts as 1, values above MAX_NODES clamp).
//  - A parent write or a node count write marks the doubling table stale. The next in-range
//    query first rebuilds the table: for level 0 a parent read and a table write per node,
//    then for each further level two table reads through its single read port and a write
//    per node, over the n active nodes.
//  - A query on a built table walks the step bits from the lowest up in S_Q_RD, with a table
//    read and an S_Q_CHK range check for each set bit, until no set bit is left or a hop
//    leaves the nodes in use, then loads the response register in S_RSP. Out-of-range queries go straight to S_RSP.
//  - One item is in flight at a time: req_stall is high while a query works. A parent write
//    does not raise req_stall. A finished response sits in the output register; the next item is
//    accepted while it waits for the receiver.
//  - rsp_stall holds the response register and its payload; the controller waits with the
//    next result until the register drains.
//  - reset clears the controller, empties the output register, sets the node count to 1
//    and marks the table stale. The memories are not cleared.
module kth_ancestor_binary_lifting import kal_pkg::*; #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [NODE_W-1:0]  req_node,
   input  logic [NODE_W-1:0]  req_parent,
   input  logic [STEPS_W-1:0] req_steps,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [NODE_W-1:0]  rsp_ancestor,
   output logic               rsp_found,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   localparam int NW  = $clog2(MAX_NODES);
   localparam int AW  = $clog2(MAX_NODES + 1);
   localparam int LVW = $clog2(LEVELS);
   localparam int CW  = (AW > COUNT_W) ? AW : COUNT_W;
   localparam logic [AW-1:0] NO_NODE = AW'(MAX_NODES);

   state_type         state_ff, state_in;
   logic [AW-1:0]     n_ff, n_in;
   logic              stale_ff, stale_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [LVW-1:0]    lvl_ff, lvl_in;
   logic [AW-1:0]     cur_ff, cur_in;
   logic [LEVELS-1:0] steps_ff, steps_in;
   logic              hop_ff, hop_in;
   logic              res_found_ff, res_found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] rsp_anc_ff, rsp_anc_in;
   logic              rsp_found_ff, rsp_found_in;

   logic              par_wr_en;
   logic              par_rd_en;
   logic [NW-1:0]     par_rd_idx;
   logic [NODE_W-1:0] par_rd_data;

   logic              lift_wr_en;
   logic [LVW-1:0]    lift_wr_lvl;
   logic [NW-1:0]     lift_wr_idx;
   logic [AW-1:0]     lift_wr_data;
   logic              lift_rd_en;
   logic [LVW-1:0]    lift_rd_lvl;
   logic [NW-1:0]     lift_rd_idx;
   logic [AW-1:0]     lift_rd_data;

   logic              req_take;
   logic              node_fits;
   logic              query_ok;
   logic              out_free;
   logic              idx_last;
   logic              lvl_last;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign node_fits = CW'(req_node) < CW'(MAX_NODES);
   // queried node must be in use and the step count must fit the table levels
   assign query_ok  = (CW'(req_node) < CW'(n_ff)) && ((req_steps >> LEVELS) == '0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_last  = (idx_ff == n_ff - AW'(1));
   assign lvl_last  = (lvl_ff == LVW'(LEVELS - 1));

   kal_parent_mem #(
      .MAX_NODES(MAX_NODES)
   ) u_parent (
      .clock   (clock),
      .wr_en   (par_wr_en),
      .wr_idx  (NW'(req_node)),
      .wr_data (req_parent),
      .rd_en   (par_rd_en),
      .rd_idx  (par_rd_idx),
      .rd_data (par_rd_data)
   );

   kal_lift_mem #(
      .MAX_NODES(MAX_NODES),
      .LEVELS   (LEVELS)
   ) u_lift (
      .clock   (clock),
      .wr_en   (lift_wr_en),
      .wr_lvl  (lift_wr_lvl),
      .wr_idx  (lift_wr_idx),
      .wr_data (lift_wr_data),
      .rd_en   (lift_rd_en),
      .rd_lvl  (lift_rd_lvl),
      .rd_idx  (lift_rd_idx),
      .rd_data (lift_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      stale_in     = stale_ff;
      idx_in       = idx_ff;
      lvl_in       = lvl_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      hop_in       = hop_ff;
      res_found_in = res_found_ff;
      // drop the response once the receiver takes it
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_anc_in   = rsp_anc_ff;
      rsp_found_in = rsp_found_ff;

      par_wr_en    = 1'b0;
      par_rd_en    = 1'b0;
      par_rd_idx   = NW'(idx_ff);
      lift_wr_en   = 1'b0;
      lift_wr_lvl  = lvl_ff;
      lift_wr_idx  = NW'(idx_ff);
      lift_wr_data = NO_NODE;
      lift_rd_en   = 1'b0;
      lift_rd_lvl  = lvl_ff;
      lift_rd_idx  = NW'(idx_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_func == FUNC_WRITE) begin
                  par_wr_en = node_fits;
                  stale_in  = stale_ff || node_fits;
               end else begin
                  cur_in   = AW'(req_node);
                  steps_in = LEVELS'(req_steps);
                  lvl_in   = '0;
                  idx_in   = '0;
                  if (!query_ok) begin
                     res_found_in = 1'b0;
                     state_in     = S_RSP;
                  end else if (stale_ff) begin
                     state_in = S_P_RD;
                  end else begin
                     state_in = S_Q_RD;
                  end
               end
            end
         end
         S_P_RD: begin
            par_rd_en = 1'b1;
            state_in  = S_P_WR;
         end
         S_P_WR: begin
            // level 0: the root and out-of-range parents have no parent
            lift_wr_en  = 1'b1;
            lift_wr_lvl = '0;
            if (idx_ff != '0 && CW'(par_rd_data) < CW'(n_ff)) begin
               lift_wr_data = AW'(par_rd_data);
            end
            if (idx_last) begin
               idx_in   = '0;
               lvl_in   = LVW'(1);
               state_in = S_L_RD1;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = S_P_RD;
            end
         end
         S_L_RD1: begin
            lift_rd_en  = 1'b1;
            lift_rd_lvl = lvl_ff - LVW'(1);
            state_in    = S_L_RD2;
         end
         S_L_RD2: begin
            // follow the midpoint one level down when it names a node in use
            hop_in      = lift_rd_data < n_ff;
            lift_rd_en  = lift_rd_data < n_ff;
            lift_rd_lvl = lvl_ff - LVW'(1);
            lift_rd_idx = NW'(lift_rd_data);
            state_in    = S_L_WR;
         end
         S_L_WR: begin
            lift_wr_en = 1'b1;
            if (hop_ff) begin
               lift_wr_data = lift_rd_data;
            end
            if (!idx_last) begin
               idx_in   = idx_ff + AW'(1);
               state_in = S_L_RD1;
            end else if (!lvl_last) begin
               idx_in   = '0;
               lvl_in   = lvl_ff + LVW'(1);
               state_in = S_L_RD1;
            end else begin
               stale_in = 1'b0;
               lvl_in   = '0;
               state_in = S_Q_RD;
            end
         end
         S_Q_RD: begin
            if (steps_ff == '0) begin
               res_found_in = 1'b1;
               state_in     = S_RSP;
            end else if (steps_ff[0]) begin
               lift_rd_en  = 1'b1;
               lift_rd_idx = NW'(cur_ff);
               state_in    = S_Q_CHK;
            end else begin
               steps_in = steps_ff >> 1;
               lvl_in   = lvl_ff + LVW'(1);
            end
         end
         S_Q_CHK: begin
            if (lift_rd_data >= n_ff) begin
               res_found_in = 1'b0;
               state_in     = S_RSP;
            end else begin
               cur_in   = lift_rd_data;
               steps_in = steps_ff >> 1;
               lvl_in   = lvl_ff + LVW'(1);
               state_in = S_Q_RD;
            end
         end
         S_RSP: begin
            // hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_anc_in   = res_found_ff ? NODE_W'(cur_ff) : '0;
               rsp_found_in = res_found_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         stale_in = 1'b1;
         if (csr_wr_data == '0) begin
            n_in = AW'(1);
         end else if (CW'(csr_wr_data) > CW'(MAX_NODES)) begin
            n_in = AW'(MAX_NODES);
         end else begin
            n_in = AW'(csr_wr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= AW'(1);
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      lvl_ff       <= lvl_in;
      cur_ff       <= cur_in;
      steps_ff     <= steps_in;
      hop_ff       <= hop_in;
      res_found_ff <= res_found_in;
      rsp_anc_ff   <= rsp_anc_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_anc_ff;
   assign rsp_found    = rsp_found_ff;

   a_rebuild_first: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_func == FUNC_QUERY && query_ok && stale_ff) |=> state_ff == S_P_RD)
      else $error("valid query on a stale table did not start a rebuild");

   a_chk_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_CHK) |-> $past(state_ff) == S_Q_RD)
      else $error("range check without a preceding table read");

   a_stale_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(stale_ff) |-> $past(state_ff) == S_L_WR)
      else $error("table marked built outside the last rebuild write");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> rsp_anc_ff == '0)
      else $error("missed query carries a nonzero ancestor");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the binary lifting k-th ancestor block.
module testbench;
   import kal_pkg::*;

   localparam int NODE_SLOTS     = 1024;
   localparam int LIFT_LEVELS    = 11;
   localparam logic [COUNT_W-1:0] NO_ANCESTOR = COUNT_W'(NODE_SLOTS);
   // Slowest quiet stretch: a full rebuild at 1024 nodes plus a query, a stall burst
   // and a sender gap. Allow several times that.
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int RANDOM_ITEMS   = 80;
   localparam int MAX_REPORTS    = 40;
   localparam int SETTLE_CYCLES  = 10;

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic              found;
   } ancestor_answer_type;

   typedef enum int {
      SHAPE_CHAIN,
      SHAPE_RANDOM,
      SHAPE_BUSHY
   } tree_shape_type;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic               req_func    = FUNC_WRITE;
   logic [NODE_W-1:0]  req_node    = '0;
   logic [NODE_W-1:0]  req_parent  = '0;
   logic [STEPS_W-1:0] req_steps   = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic [NODE_W-1:0]  rsp_ancestor;
   logic               rsp_found;
   logic               csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;

   // Mirror of the block state, kept in step with every accepted beat.
   logic [NODE_W-1:0]  parent_mirror [NODE_SLOTS];
   logic [COUNT_W-1:0] lift_mirror   [NODE_SLOTS][LIFT_LEVELS];
   logic               table_stale = 1'b1;
   logic [COUNT_W-1:0] node_count_mirror = COUNT_W'(1);

   ancestor_answer_type pending_answers [$];
   int                 error_count = 0;
   int                 items_sent  = 0;
   int                 quiet_cycles = 0;
   // Random idling on both channels is enabled only while this is set.
   bit                 idle_on = 1'b0;
   int                 stall_left = 0;

   kth_ancestor_binary_lifting #(
      .MAX_NODES (NODE_SLOTS),
      .LEVELS    (LIFT_LEVELS)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_node     (req_node),
      .req_parent   (req_parent),
      .req_steps    (req_steps),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_ancestor (rsp_ancestor),
      .rsp_found    (rsp_found),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Ancestor predictor
   // ---------------------------------------------------------------------------------------

   // Clamp the node count the way the block does: 0 acts as 1, above the slot count clamps.
   function automatic int unsigned nodes_in_use();
      if (node_count_mirror == '0) return 1;
      if (node_count_mirror > NODE_SLOTS) return NODE_SLOTS;
      return node_count_mirror;
   endfunction

   // Rebuild the doubling table. Entries at or above the node count are never followed,
   // so only the live nodes are filled in.
   function automatic void rebuild_lift_mirror();
      int unsigned        n;
      logic [COUNT_W-1:0] mid;
      n = nodes_in_use();
      for (int i = 0; i < n; i++) begin
         if (i == 0 || parent_mirror[i] >= n) lift_mirror[i][0] = NO_ANCESTOR;
         else lift_mirror[i][0] = {1'b0, parent_mirror[i]};
      end
      for (int j = 1; j < LIFT_LEVELS; j++) begin
         for (int i = 0; i < n; i++) begin
            mid = lift_mirror[i][j-1];
            lift_mirror[i][j] = (mid < n) ? lift_mirror[mid][j-1] : NO_ANCESTOR;
         end
      end
      table_stale = 1'b0;
   endfunction

   // Apply one accepted beat: store a parent, or walk the lifting table and queue the answer.
   function automatic void apply_item(input logic item_func, input logic [NODE_W-1:0] item_node,
                                      input logic [NODE_W-1:0] item_parent,
                                      input logic [STEPS_W-1:0] item_steps);
      int unsigned         n;
      logic [COUNT_W-1:0]  cur;
      bit                  lost;
      ancestor_answer_type answer;
      if (item_func == FUNC_WRITE) begin
         parent_mirror[item_node] = item_parent;
         table_stale = 1'b1;
         return;
      end
      if (table_stale) rebuild_lift_mirror();
      n = nodes_in_use();
      answer = '{ancestor: '0, found: 1'b0};
      // Step counts with any bit at or above the level count run past the root.
      if (item_node < n && item_steps[STEPS_W-1:LIFT_LEVELS] == '0) begin
         cur  = {1'b0, item_node};
         lost = 1'b0;
         for (int j = 0; j < LIFT_LEVELS; j++) begin
            if (!lost && item_steps[j]) begin
               cur = lift_mirror[cur][j];
               if (cur >= n) lost = 1'b1;
            end
         end
         if (!lost) answer = '{ancestor: cur[NODE_W-1:0], found: 1'b1};
      end
      pending_answers = {pending_answers, answer};
   endfunction

   // ---------------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS) $display("tb: mismatch: %s", msg);
      error_count++;
   endtask

   // Compare every accepted result beat with the oldest queued answer.
   always @(posedge clock) begin
      ancestor_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending: ancestor=%0d found=%b",
                                      rsp_ancestor, rsp_found));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_ancestor !== want.ancestor)
               report_mismatch($sformatf("ancestor got %0d want %0d", rsp_ancestor,
                                         want.ancestor));
            if (rsp_found !== want.found)
               report_mismatch($sformatf("found got %b want %b", rsp_found, want.found));
         end
      end
   end

   // Count cycles in which neither channel moves a beat; give up at the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Receiver side: hold off results in random bursts while idling is enabled.
   always @(posedge clock) begin
      if (stall_left != 0) stall_left--;
      else if (idle_on && !reset && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
      rsp_stall <= (stall_left != 0);
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   // Drive one request beat and hold it until the block takes it. Valid stays high after
   // acceptance so back-to-back beats need no extra assignment.
   task automatic send_item(input logic item_func, input logic [NODE_W-1:0] item_node,
                            input logic [NODE_W-1:0] item_parent,
                            input logic [STEPS_W-1:0] item_steps);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= item_func;
      req_node   <= item_node;
      req_parent <= item_parent;
      req_steps  <= item_steps;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_item(item_func, item_node, item_parent, item_steps);
      items_sent++;
   endtask

   // Drop valid, wait for every answer, then let a trailing parent write settle.
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Write the node count while the block is idle.
   task automatic set_node_count(input logic [COUNT_W-1:0] value);
      drain(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      node_count_mirror = value;
      table_stale = 1'b1;
   endtask

   // Mostly depths that land inside the tree, plus whole-range and oversize step counts.
   function automatic logic [STEPS_W-1:0] pick_steps(input int n);
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2, 3: return STEPS_W'($urandom_range(1, n));
         4, 5:    return STEPS_W'($urandom_range(1, 12));
         6, 7:    return STEPS_W'($urandom_range(0, 2047));
         8:       return STEPS_W'($urandom_range(2048, 20'hFFFFF));
         default: return STEPS_W'($urandom);
      endcase
   endfunction

   function automatic logic [NODE_W-1:0] pick_query_node(input int n);
      if ($urandom_range(0, 9) == 0) return NODE_W'($urandom_range(0, NODE_SLOTS - 1));
      return NODE_W'($urandom_range(0, n - 1));
   endfunction

   // Write a parent for every node below n. The root gets a random parent, which must
   // have no effect.
   task automatic load_tree(input int n, input tree_shape_type shape);
      int up;
      send_item(FUNC_WRITE, '0, NODE_W'($urandom), '0);
      for (int i = 1; i < n; i++) begin
         case (shape)
            SHAPE_CHAIN: up = i - 1;
            SHAPE_BUSHY: up = i / 2;
            default:     up = ($urandom_range(0, 3) == 0) ? i - 1 : $urandom_range(0, i - 1);
         endcase
         send_item(FUNC_WRITE, NODE_W'(i), NODE_W'(up), STEPS_W'($urandom));
      end
   endtask

   // One random phase: new node count, fresh tree, then groups of edits and queries.
   // Edits are mostly well formed (parent below the node); the rest are noise that may
   // land out of range or close a cycle.
   task automatic run_phase(input int n);
      int             nd;
      tree_shape_type shape;
      shape = tree_shape_type'($urandom_range(0, 2));
      set_node_count(COUNT_W'(n));
      load_tree(n, shape);
      repeat ($urandom_range(6, 14)) begin
         repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 5) == 0) begin
               send_item(FUNC_WRITE, NODE_W'($urandom), NODE_W'($urandom), STEPS_W'($urandom));
            end else begin
               nd = $urandom_range(1, n - 1);
               send_item(FUNC_WRITE, NODE_W'(nd), NODE_W'($urandom_range(0, nd - 1)),
                         STEPS_W'($urandom));
            end
         end
         repeat ($urandom_range(1, 6))
            send_item(FUNC_QUERY, pick_query_node(n), NODE_W'($urandom), pick_steps(n));
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Give every parent slot a value first, so no rebuild ever reads an unwritten entry.
   task automatic test_load_tree();
      load_tree(NODE_SLOTS, SHAPE_RANDOM);
   endtask

   task automatic test_directed_cases();
      // Single-node tree: only the root, and zero steps is the one hit.
      set_node_count(COUNT_W'(1));
      send_item(FUNC_QUERY, '0, '0, '0);
      send_item(FUNC_QUERY, '0, '0, STEPS_W'(1));
      send_item(FUNC_QUERY, NODE_W'(1023), '1, '0);
      // A node count of zero acts as one.
      set_node_count('0);
      send_item(FUNC_QUERY, '0, '0, '0);
      // Eight-node chain, then a write to the root that must change nothing.
      set_node_count(COUNT_W'(8));
      for (int i = 1; i < 8; i++) send_item(FUNC_WRITE, NODE_W'(i), NODE_W'(i - 1), '0);
      send_item(FUNC_WRITE, '0, NODE_W'(5), '0);
      send_item(FUNC_QUERY, NODE_W'(7), '0, STEPS_W'(7));
      send_item(FUNC_QUERY, NODE_W'(7), '0, STEPS_W'(8));
      send_item(FUNC_QUERY, NODE_W'(6), '0, '0);
      send_item(FUNC_QUERY, NODE_W'(7), '0, STEPS_W'(2048));
      send_item(FUNC_QUERY, NODE_W'(7), '0, '1);
      send_item(FUNC_QUERY, NODE_W'(7), '0, STEPS_W'(2047));
      // Parent beyond the node count cuts the chain at node 3.
      send_item(FUNC_WRITE, NODE_W'(3), '1, '0);
      send_item(FUNC_QUERY, NODE_W'(5), '0, STEPS_W'(2));
      send_item(FUNC_QUERY, NODE_W'(5), '0, STEPS_W'(3));
      // Write to a node beyond the count is stored; a query on it misses.
      send_item(FUNC_WRITE, NODE_W'(900), NODE_W'(1), '0);
      send_item(FUNC_QUERY, NODE_W'(900), '0, '0);
      // Close a cycle between nodes 1 and 2 and walk around it.
      send_item(FUNC_WRITE, NODE_W'(1), NODE_W'(2), '0);
      send_item(FUNC_QUERY, NODE_W'(2), '0, STEPS_W'(1001));
   endtask

   // Full-size tree: few rebuilds, since each one walks all 1024 nodes.
   task automatic test_full_size();
      idle_on = 1'b1;
      set_node_count(COUNT_W'(NODE_SLOTS));
      send_item(FUNC_QUERY, NODE_W'(1023), '0, '0);
      repeat (30)
         send_item(FUNC_QUERY, pick_query_node(NODE_SLOTS), NODE_W'($urandom),
                   pick_steps(NODE_SLOTS));
      send_item(FUNC_WRITE, NODE_W'(5), NODE_W'(1023), '0);
      send_item(FUNC_WRITE, NODE_W'(1023), NODE_W'(1022), '0);
      send_item(FUNC_QUERY, NODE_W'(1023), '0, STEPS_W'(1));
      send_item(FUNC_QUERY, NODE_W'(5), '0, STEPS_W'(2));
      repeat (10)
         send_item(FUNC_QUERY, pick_query_node(NODE_SLOTS), NODE_W'($urandom),
                   pick_steps(NODE_SLOTS));
      // All ones clamps to the slot count.
      set_node_count('1);
      repeat (10)
         send_item(FUNC_QUERY, pick_query_node(NODE_SLOTS), NODE_W'($urandom),
                   pick_steps(NODE_SLOTS));
   endtask

   // Mostly small trees so rebuilds stay cheap; now and then a mid-size one.
   task automatic test_random_phases();
      int stop_at;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 7) == 0) run_phase($urandom_range(49, 200));
         else run_phase($urandom_range(2, 48));
      end
   endtask

   // Close out at full rate on both channels.
   task automatic test_quiet_finish();
      idle_on = 1'b0;
      run_phase($urandom_range(2, 48));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_load_tree();
      test_directed_cases();
      test_full_size();
      test_random_phases();
      test_quiet_finish();
      drain(2 * LIFT_LEVELS + 8);
      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
